// ===== rtl/core/gap_distance_group_sort_macros.svh =====
// ----------------------------------------------------------------------------
// gap_distance_group_sort assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAP_DISTANCE_GROUP_SORT_MACROS_SVH
`define GAP_DISTANCE_GROUP_SORT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define GDGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GDGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition holds at every clock edge out of reset.
`define GDGS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/gdgs_pkg.sv =====
// ----------------------------------------------------------------------------
// gdgs_pkg
// Closure kind codes and the command and status bundles between the
// sort controller and the datapath.
// ----------------------------------------------------------------------------
package gdgs_pkg;

    localparam logic [1:0] KIND_OVERLAP = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_LEFT    = 2'd2;
    localparam logic [1:0] KIND_RIGHT   = 2'd3;

    localparam logic [1:0] GROUP_GAP   = 2'd0;
    localparam logic [1:0] GROUP_LEFT  = 2'd1;
    localparam logic [1:0] GROUP_RIGHT = 2'd2;

    localparam int GAP_W = 17;
    localparam int KEY_OUT_W = 17;

    typedef struct packed {
        logic store;
        logic scan_start;
        logic load_out;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic final_out;
    } dp_status_t;

endpackage

// ===== rtl/core/gdgs_ram.sv =====
// ----------------------------------------------------------------------------
// gdgs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module gdgs_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/gdgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdgs_ctrl
// Sequencer: collects records, then alternates one selection scan and one
// result emission until every held record has gone out.
// ----------------------------------------------------------------------------
`include "gap_distance_group_sort_macros.svh"

module gdgs_ctrl
    import gdgs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       last_in,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        ST_COLLECT = 3'b001,
        ST_SCAN    = 3'b010,
        ST_EMIT    = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == ST_COLLECT);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (last_in)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.final_out)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `GDGS_ASSERT_NEXT(a_last_starts_scan, in_valid && in_ready && last_in,
        state_reg == ST_SCAN, "last word did not start a scan")
    `GDGS_ASSERT_NEXT(a_final_returns, out_valid && out_ready && status.final_out,
        in_ready, "final result did not reopen collection")
    `GDGS_ASSERT_SAME(a_load_in_scan, cmd.load_out,
        state_reg == ST_SCAN, "result loaded outside a scan")

endmodule

// ===== rtl/core/gdgs_dp.sv =====
// ----------------------------------------------------------------------------
// gdgs_dp
// Record store, key builder and selection scan. Each scan walks every held
// record and picks the smallest {group, key, index} above the last one sent.
// ----------------------------------------------------------------------------
`include "gap_distance_group_sort_macros.svh"

module gdgs_dp
    import gdgs_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int LENGTH_BITS = 16,
    localparam int IW = $clog2(MAX_RECORDS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [GAP_W-1:0]       gap_target,
    input  logic [1:0]             kind,
    input  logic [LENGTH_BITS-1:0] seq_length,
    input  logic [LENGTH_BITS-1:0] overlap_len,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    output logic [IW-1:0]          source_index,
    output logic [1:0]             kind_out,
    output logic [LENGTH_BITS-1:0] length_out,
    output logic [LENGTH_BITS-1:0] overlap_out,
    output logic [KEY_OUT_W-1:0]   sort_key,
    output logic                   last_out,
    output logic                   dropped
);

    localparam int CW   = $clog2(MAX_RECORDS + 1);
    localparam int KW   = ((LENGTH_BITS > GAP_W) ? LENGTH_BITS : GAP_W) + 1;
    localparam int SW   = KW + 1;
    localparam int DW   = 2 + 2 * LENGTH_BITS;
    localparam int CMPW = 2 + KW + IW;
    localparam logic [KW-1:0] KEY_SAT = KW'((1 << KEY_OUT_W) - 1);

    // Configuration and set bookkeeping.
    logic [GAP_W-1:0] gap_reg;
    logic [CW-1:0]    count_reg;
    logic             ovf_reg;
    logic [CW-1:0]    emit_cnt_reg;
    logic             full;
    logic [CW-1:0]    count_m1;

    // Scan pipeline.
    logic            scan_active_reg;
    logic            issue_reg;
    logic [IW-1:0]   addr_reg;
    logic            v1_reg;
    logic [IW-1:0]   idx1_reg;
    logic [DW-1:0]   rd_data;
    logic            v2_reg;
    logic [CMPW-1:0] comp2_reg;
    logic [DW-1:0]   data2_reg;
    logic            best_valid_reg;
    logic [CMPW-1:0] best_reg;
    logic [DW-1:0]   best_data_reg;
    logic            have_prev_reg;
    logic [CMPW-1:0] prev_reg;

    // Key build on the word read from the store.
    logic [1:0]             rd_kind;
    logic [LENGTH_BITS-1:0] rd_len;
    logic [LENGTH_BITS-1:0] rd_ov;
    logic signed [SW-1:0]   gap_ext;
    logic signed [SW-1:0]   diff;
    logic [KW-1:0]          gap_dist;
    logic [KW-1:0]          key1;
    logic [1:0]             group1;
    logic                   take;

    // Output word.
    logic [IW-1:0]          out_idx_reg;
    logic [1:0]             out_kind_reg;
    logic [LENGTH_BITS-1:0] out_len_reg;
    logic [LENGTH_BITS-1:0] out_ov_reg;
    logic [KEY_OUT_W-1:0]   out_key_reg;
    logic                   out_last_reg;
    logic [1:0]             best_kind;
    logic [KW-1:0]          best_key;

    assign full     = (count_reg == CW'(MAX_RECORDS));
    assign count_m1 = count_reg - CW'(1);

    gdgs_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_RECORDS)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.store && !full),
        .wr_addr(count_reg[IW-1:0]),
        .wr_data({kind, seq_length, overlap_len}),
        .rd_en  (issue_reg),
        .rd_addr(addr_reg),
        .rd_data(rd_data)
    );

    assign rd_kind = rd_data[DW-1 -: 2];
    assign rd_len  = rd_data[2*LENGTH_BITS-1 -: LENGTH_BITS];
    assign rd_ov   = rd_data[LENGTH_BITS-1:0];
    assign gap_ext = {{(SW-GAP_W){gap_reg[GAP_W-1]}}, gap_reg};

    always_comb
    begin
        if (rd_kind == KIND_OVERLAP)
        begin
            diff = -$signed(SW'(rd_ov)) - gap_ext;
        end
        else
        begin
            diff = $signed(SW'(rd_len)) - gap_ext;
        end
        gap_dist = diff[SW-1] ? KW'(-diff) : diff[KW-1:0];
        case (rd_kind)
            KIND_OVERLAP, KIND_FULL:
            begin
                group1 = GROUP_GAP;
                key1   = gap_dist;
            end
            KIND_LEFT:
            begin
                group1 = GROUP_LEFT;
                key1   = KW'(rd_len);
            end
            default:
            begin
                group1 = GROUP_RIGHT;
                key1   = KW'(rd_len);
            end
        endcase
    end

    // A candidate wins when it lies above the last record sent and below
    // the best one found so far in this scan. The index makes every tuple
    // distinct, so ties resolve by arrival order.
    assign take = v2_reg
        && (!have_prev_reg || (comp2_reg > prev_reg))
        && (!best_valid_reg || (comp2_reg < best_reg));

    assign best_kind = best_data_reg[DW-1 -: 2];
    assign best_key  = best_reg[IW +: KW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg         <= '0;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            emit_cnt_reg    <= '0;
            scan_active_reg <= 1'b0;
            issue_reg       <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            best_valid_reg  <= 1'b0;
            have_prev_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gap_reg <= gap_target;
            end
            if (cmd.store)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            if (cmd.scan_start)
            begin
                scan_active_reg <= 1'b1;
                issue_reg       <= 1'b1;
                best_valid_reg  <= 1'b0;
            end
            else if (issue_reg && (addr_reg == count_m1[IW-1:0]))
            begin
                issue_reg <= 1'b0;
            end
            if (take)
            begin
                best_valid_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                scan_active_reg <= 1'b0;
                have_prev_reg   <= 1'b1;
                emit_cnt_reg    <= emit_cnt_reg + CW'(1);
                out_last_reg    <= ((emit_cnt_reg + CW'(1)) == count_reg);
            end
            if (cmd.finish)
            begin
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
                emit_cnt_reg  <= '0;
                have_prev_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            addr_reg <= '0;
        end
        else if (issue_reg)
        begin
            addr_reg <= addr_reg + IW'(1);
        end
        idx1_reg  <= addr_reg;
        comp2_reg <= {group1, key1, idx1_reg};
        data2_reg <= rd_data;
        if (take)
        begin
            best_reg      <= comp2_reg;
            best_data_reg <= data2_reg;
        end
        if (cmd.load_out)
        begin
            prev_reg     <= best_reg;
            out_idx_reg  <= best_reg[IW-1:0];
            out_kind_reg <= best_kind;
            out_len_reg  <= best_data_reg[2*LENGTH_BITS-1 -: LENGTH_BITS];
            out_ov_reg   <= (best_kind == KIND_OVERLAP) ?
                            best_data_reg[LENGTH_BITS-1:0] : '0;
            out_key_reg  <= (best_key > KEY_SAT) ? KEY_SAT[KEY_OUT_W-1:0] :
                            best_key[KEY_OUT_W-1:0];
        end
    end

    assign status.scan_done = scan_active_reg && !issue_reg && !v1_reg && !v2_reg;
    assign status.final_out = out_last_reg;

    assign source_index = out_idx_reg;
    assign kind_out     = out_kind_reg;
    assign length_out   = out_len_reg;
    assign overlap_out  = out_ov_reg;
    assign sort_key     = out_key_reg;
    assign last_out     = out_last_reg;
    assign dropped      = ovf_reg;

    `GDGS_ASSERT_SAME(a_scan_found, cmd.load_out,
        best_valid_reg, "scan ended without a selected record")
    `GDGS_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(MAX_RECORDS),
        "record count exceeds capacity")
    `GDGS_ASSERT_ALWAYS(a_emit_bound, emit_cnt_reg <= count_reg,
        "more results sent than records held")

endmodule

// ===== rtl/core/gap_distance_group_sort.sv =====
// Collection: one record per cycle while no set is being sent.
// After the last record, and after each accepted result, a scan over the n
// held records picks the next result, which is offered the cycle after the
// scan ends.
// Reset (rst_n, asynchronous, active low) empties the set and clears the gap
// setting to 0; record storage needs no clearing pass.
// ----------------------------------------------------------------------------
// gap_distance_group_sort
// Collects a set of gap-closure records and sends them back in gap, left and
// right groups, ordered by distance to the expected gap or by length.
// ----------------------------------------------------------------------------
module gap_distance_group_sort
    import gdgs_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int LENGTH_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [GAP_W-1:0]               gap_target,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     kind,
    input  logic [LENGTH_BITS-1:0]         seq_length,
    input  logic [LENGTH_BITS-1:0]         overlap_len,
    input  logic                           last_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [$clog2(MAX_RECORDS)-1:0] source_index,
    output logic [1:0]                     kind_out,
    output logic [LENGTH_BITS-1:0]         length_out,
    output logic [LENGTH_BITS-1:0]         overlap_out,
    output logic [KEY_OUT_W-1:0]           sort_key,
    output logic                           last_out,
    output logic                           dropped
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    gdgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_in  (last_in),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .status   (status)
    );

    gdgs_dp #(
        .MAX_RECORDS(MAX_RECORDS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .gap_target  (gap_target),
        .kind        (kind),
        .seq_length  (seq_length),
        .overlap_len (overlap_len),
        .cmd         (cmd),
        .status      (status),
        .source_index(source_index),
        .kind_out    (kind_out),
        .length_out  (length_out),
        .overlap_out (overlap_out),
        .sort_key    (sort_key),
        .last_out    (last_out),
        .dropped     (dropped)
    );

endmodule

// ===== tb/gap_sort_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_sort_check_pkg
// Expected-order bookkeeping for the gap-closure group sort: holds the
// current record set, computes the order the block must emit, and checks
// each emitted word against it.
// ----------------------------------------------------------------------------
package gap_sort_check_pkg;

    import gdgs_pkg::*;

    localparam int CAPACITY = 64;
    localparam longint KEY_LIMIT = (longint'(1) << KEY_OUT_W) - 1;

    typedef struct packed {
        logic [5:0]           src;
        logic [1:0]           kind;
        logic [15:0]          len;
        logic [15:0]          ovl;
        logic [KEY_OUT_W-1:0] key;
        logic                 last;
        logic                 drop;
    } sorted_word_t;

    class closure_sort_board;

        logic [1:0]              kinds [CAPACITY];
        logic [15:0]             lens  [CAPACITY];
        logic [15:0]             ovls  [CAPACITY];
        int unsigned             held;
        bit                      overflowed;
        logic signed [GAP_W-1:0] gap;
        sorted_word_t            pending_words [$];

        int unsigned records;
        int unsigned sets;
        int unsigned overflow_sets;
        int unsigned words_checked;
        int unsigned mismatches;

        function new();
            held = 0;
            overflowed = 0;
            gap = '0;
            records = 0;
            sets = 0;
            overflow_sets = 0;
            words_checked = 0;
            mismatches = 0;
        endfunction

        function void set_gap(logic [GAP_W-1:0] value);
            gap = value;
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction

        // Stores one accepted record; the record that closes a set queues the
        // whole set in the order the block has to send it.
        function void note_record(logic [1:0] k, logic [15:0] len, logic [15:0] ovl,
                                  logic last);
            int unsigned  grp       [CAPACITY];
            longint       key       [CAPACITY];
            int unsigned  order_idx [CAPACITY];
            longint       diff;
            int unsigned  cur;
            int unsigned  prev;
            int unsigned  j;
            int unsigned  r;
            sorted_word_t w;
            records++;
            if (held < CAPACITY) begin
                kinds[held] = k;
                lens[held] = len;
                ovls[held] = ovl;
                held++;
            end
            else begin
                overflowed = 1;
            end
            if (!last)
                return;

            for (int unsigned i = 0; i < held; i++) begin
                case (kinds[i])
                    KIND_OVERLAP: begin
                        grp[i] = GROUP_GAP;
                        diff = -longint'(ovls[i]) - longint'(gap);
                        key[i] = (diff < 0) ? -diff : diff;
                    end
                    KIND_FULL: begin
                        grp[i] = GROUP_GAP;
                        diff = longint'(lens[i]) - longint'(gap);
                        key[i] = (diff < 0) ? -diff : diff;
                    end
                    KIND_LEFT: begin
                        grp[i] = GROUP_LEFT;
                        key[i] = longint'(lens[i]);
                    end
                    default: begin
                        grp[i] = GROUP_RIGHT;
                        key[i] = longint'(lens[i]);
                    end
                endcase
                order_idx[i] = i;
            end

            // Insertion sort; a later record only moves past strictly greater
            // ones, so equal keys stay in arrival order.
            for (int unsigned i = 1; i < held; i++) begin
                cur = order_idx[i];
                j = i;
                while (j > 0) begin
                    prev = order_idx[j-1];
                    if (grp[prev] < grp[cur] || (grp[prev] == grp[cur] && key[prev] <= key[cur]))
                        break;
                    order_idx[j] = prev;
                    j--;
                end
                order_idx[j] = cur;
            end

            for (int unsigned i = 0; i < held; i++) begin
                r = order_idx[i];
                w.src = r[5:0];
                w.kind = kinds[r];
                w.len = lens[r];
                w.ovl = (kinds[r] == KIND_OVERLAP) ? ovls[r] : '0;
                w.key = (key[r] > KEY_LIMIT) ? '1 : key[r][KEY_OUT_W-1:0];
                w.last = (i == held - 1);
                w.drop = overflowed;
                pending_words = {pending_words, w};
            end
            sets++;
            if (overflowed)
                overflow_sets++;
            held = 0;
            overflowed = 0;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(sorted_word_t got);
            sorted_word_t want;
            words_checked++;
            if (pending_words.size() == 0) begin
                $display("%0t: word with nothing expected, index %0d kind %0d length %0d",
                         $time, got.src, got.kind, got.len);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            compare("source_index", want.src, got.src);
            compare("kind_out", want.kind, got.kind);
            compare("length_out", want.len, got.len);
            compare("overlap_out", want.ovl, got.ovl);
            compare("sort_key", want.key, got.key);
            compare("last_out", want.last, got.last);
            compare("dropped", want.drop, got.drop);
        endfunction

    endclass

endpackage

// ===== tb/tb_gap_distance_group_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_distance_group_sort
// Sends sets of gap-closure records under several gap settings, with random
// sender bursts and receiver stalls, and checks every sorted word in order.
// ----------------------------------------------------------------------------
module tb_gap_distance_group_sort;

    import gdgs_pkg::*;
    import gap_sort_check_pkg::*;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } ready_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [GAP_W-1:0]     gap_target;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [15:0]          seq_length;
    logic [15:0]          overlap_len;
    logic                 last_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [5:0]           source_index;
    logic [1:0]           kind_out;
    logic [15:0]          length_out;
    logic [15:0]          overlap_out;
    logic [KEY_OUT_W-1:0] sort_key;
    logic                 last_out;
    logic                 dropped;

    closure_sort_board board = new();

    int unsigned items_sent = 0;
    int unsigned gap_writes = 0;
    int unsigned burst_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned ready_span = 0;
    int unsigned ready_tick = 0;

    gap_distance_group_sort uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .gap_target   (gap_target),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .seq_length   (seq_length),
        .overlap_len  (overlap_len),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .source_index (source_index),
        .kind_out     (kind_out),
        .length_out   (length_out),
        .overlap_out  (overlap_out),
        .sort_key     (sort_key),
        .last_out     (last_out),
        .dropped      (dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: switches between stall patterns after spans of random length.
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1;
        if (ready_span == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_span <= $urandom_range(30, 250);
        end
        else
        begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   out_ready <= 1'b1;
            READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY:   out_ready <= ($urandom_range(0, 4) == 0);
            default:        out_ready <= ((ready_tick % 6) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_record(kind, seq_length, overlap_len, last_in);
    end

    always @(posedge clk)
    begin
        sorted_word_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.src = source_index;
            got.kind = kind_out;
            got.len = length_out;
            got.ovl = overlap_out;
            got.key = sort_key;
            got.last = last_out;
            got.drop = dropped;
            board.check_word(got);
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 24));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [GAP_W-1:0] pick_gap();
        int offset;
        offset = int'($urandom_range(0, 48)) - 24;
        case ($urandom_range(0, 7))
            0:       return 17'h10000;
            1:       return 17'h0FFFF;
            2:       return 17'h10001;
            3, 4:    return offset[GAP_W-1:0];
            default: return GAP_W'($urandom);
        endcase
    endfunction

    // The sender works in bursts; a new burst may start after an idle gap.
    task automatic send_record(input logic [1:0] k, input logic [15:0] len,
                               input logic [15:0] ovl, input logic last);
        int unsigned pause;
        pause = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0)
                pause = $urandom_range(1, 10);
        end
        burst_left--;
        if (pause != 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        seq_length <= len;
        overlap_len <= ovl;
        last_in <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random_set(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_record(2'($urandom_range(0, 3)), pick_value(), pick_value(), i == n - 1);
    endtask

    // Holds the sender off until every queued word has come back, then waits
    // with the sender still held off before returning.
    task automatic drain_sets();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] value);
        cfg_valid <= 1'b1;
        gap_target <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_gap(value);
        gap_writes++;
    endtask

    initial
    begin
        bit full_set_done;
        bit overflow_set_done;
        full_set_done = 0;
        overflow_set_done = 0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        gap_target <= '0;
        in_valid <= 1'b0;
        kind <= KIND_OVERLAP;
        seq_length <= '0;
        overlap_len <= '0;
        last_in <= 1'b0;
        out_ready <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_gap(17'h00000);
        // Zero gap: ties inside the gap group across kinds, extremes of each
        // kind, and an overlap amount on a right closure that must be ignored.
        send_record(KIND_OVERLAP, 16'hFFFF, 16'h0000, 1'b0);
        send_record(KIND_FULL,    16'h0000, 16'h1234, 1'b0);
        send_record(KIND_RIGHT,   16'h0000, 16'hFFFF, 1'b0);
        send_record(KIND_LEFT,    16'hFFFF, 16'hFFFF, 1'b0);
        send_record(KIND_OVERLAP, 16'h0000, 16'hFFFF, 1'b0);
        send_record(KIND_FULL,    16'hFFFF, 16'h0000, 1'b0);
        send_record(KIND_LEFT,    16'h0000, 16'h8000, 1'b0);
        send_record(KIND_FULL,    16'h0007, 16'h0000, 1'b0);
        send_record(KIND_OVERLAP, 16'h0003, 16'h0007, 1'b0);
        send_record(KIND_RIGHT,   16'hFFFF, 16'h0001, 1'b1);
        drain_sets();

        // Largest positive gap: the largest overlap distance.
        write_gap(17'h0FFFF);
        send_record(KIND_OVERLAP, 16'h007B, 16'hFFFF, 1'b0);
        send_record(KIND_FULL,    16'h0000, 16'h0000, 1'b0);
        send_record(KIND_FULL,    16'hFFFF, 16'h0000, 1'b0);
        send_record(KIND_RIGHT,   16'h0003, 16'h5555, 1'b0);
        send_record(KIND_LEFT,    16'hAAAA, 16'hAAAA, 1'b1);
        drain_sets();

        // Most negative pattern: the full-length key reaches the top of the range.
        write_gap(17'h10000);
        send_record(KIND_FULL,    16'hFFFF, 16'h0000, 1'b0);
        send_record(KIND_OVERLAP, 16'h0000, 16'hFFFF, 1'b0);
        send_record(KIND_OVERLAP, 16'h0000, 16'h0000, 1'b1);
        drain_sets();

        write_gap(17'h10001);
        send_record(KIND_LEFT,    16'h0001, 16'h0000, 1'b1);
        send_record(KIND_FULL,    16'h0000, 16'h0000, 1'b0);
        send_record(KIND_RIGHT,   16'h0002, 16'h0000, 1'b1);

        // Random sets, mostly small, with one full set and one that overflows
        // by two records, the closing record among the dropped ones.
        while (items_sent < 360)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drain_sets();
                write_gap(pick_gap());
            end
            if (!full_set_done && items_sent >= 120)
            begin
                send_random_set(CAPACITY);
                full_set_done = 1;
            end
            else if (!overflow_set_done && items_sent >= 240)
            begin
                send_random_set(CAPACITY + 2);
                overflow_set_done = 1;
            end
            else
            begin
                send_random_set($urandom_range(1, 8));
            end
        end
        drain_sets();

        $display("summary: %0d records in %0d sets, %0d sorted words checked, %0d mismatches",
                 board.records, board.sets, board.words_checked, board.mismatches);
        $display("summary: %0d gap settings written, %0d sets lost records to capacity",
                 gap_writes, board.overflow_sets);
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d words still expected", board.pending());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gdgs_pkg.sv
rtl/core/gdgs_ram.sv
rtl/core/gdgs_ctrl.sv
rtl/core/gdgs_dp.sv
rtl/core/gap_distance_group_sort.sv
tb/gap_sort_check_pkg.sv
tb/tb_gap_distance_group_sort.sv
